// File: sv/gpthc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the GPT checker.
`default_nettype none
package gpthc_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int POS_W        = $clog2(SECTOR_BYTES + 1);

  localparam int SIG_LEN  = 8;
  localparam int HLEN_POS = 12;
  localparam int HCRC_POS = 16;
  localparam int ECRC_POS = 88;
  localparam int MIN_HDR  = 92;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  localparam logic MODE_HEADER  = 1'b0;
  localparam logic MODE_ENTRIES = 1'b1;

  localparam logic [7:0] SIG_TEXT [SIG_LEN] = '{
    8'h45, 8'h46, 8'h49, 8'h20, 8'h50, 8'h41, 8'h52, 8'h54
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       mode;
    logic       last;
  } item_t;

  typedef struct packed {
    logic        run_kind;
    logic        signature_ok;
    logic        short_sector;
    logic        size_bad;
    logic        crc_ok;
    logic [31:0] computed_crc;
    logic [31:0] stored_crc;
  } result_t;

  function automatic logic [31:0] crc_feed(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] a;
    a = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
    end
    return a;
  endfunction

endpackage
`default_nettype wire

// File: sv/gpthc_in_stage.sv
// Input register: holds one accepted byte word until the core takes it.
`default_nettype none
module gpthc_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      data_byte,
  input  wire logic            mode,
  input  wire logic            last,
  output logic                 item_valid,
  output gpthc_pkg::item_t     item,
  input  wire logic            take
);

  logic accept;

  assign in_stall = item_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.data_byte <= data_byte;
      item.mode      <= mode;
      item.last      <= last;
    end
  end

endmodule
`default_nettype wire

// File: sv/gpthc_core.sv
// Run state, field capture, CRC update and result evaluation for one byte word.
`default_nettype none
module gpthc_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire gpthc_pkg::item_t  item,
  output logic                   take,
  input  wire logic              out_full,
  input  wire logic              out_stall,
  output logic                   res_load,
  output gpthc_pkg::result_t     res
);

  localparam int PW = gpthc_pkg::POS_W;

  logic [31:0]   crc, crc_next;
  logic [PW-1:0] pos, pos_next;
  logic          sig, sig_next;
  logic [31:0]   hlw, hlw_next;
  logic [31:0]   hcw, hcw_next;
  logic [31:0]   ecw, ecw_next;

  assign take     = item_valid && (!item.last || !out_full || !out_stall);
  assign res_load = take && item.last;

  always_comb begin
    logic [7:0]  fed;
    logic [31:0] lane_word;
    logic [31:0] pos_ext;
    crc_next  = crc;
    pos_next  = pos;
    sig_next  = sig;
    hlw_next  = hlw;
    hcw_next  = hcw;
    ecw_next  = ecw;
    fed       = item.data_byte;
    lane_word = {24'd0, item.data_byte} << {pos[1:0], 3'b000};
    pos_ext   = {{(32-PW){1'b0}}, pos};

    if (item.mode == gpthc_pkg::MODE_HEADER) begin
      if (pos < PW'(gpthc_pkg::SECTOR_BYTES)) begin
        if (pos == '0) begin
          hlw_next = '0;
          hcw_next = '0;
          ecw_next = '0;
          sig_next = 1'b1;
        end
        if (pos < PW'(gpthc_pkg::SIG_LEN) &&
            item.data_byte != gpthc_pkg::SIG_TEXT[pos[2:0]]) begin
          sig_next = 1'b0;
        end
        if (pos >= PW'(gpthc_pkg::HLEN_POS) && pos < PW'(gpthc_pkg::HCRC_POS)) begin
          hlw_next = hlw_next | lane_word;
        end
        if (pos >= PW'(gpthc_pkg::HCRC_POS) && pos < PW'(gpthc_pkg::HCRC_POS + 4)) begin
          hcw_next = hcw_next | lane_word;
          fed      = 8'd0;
        end
        if (pos >= PW'(gpthc_pkg::ECRC_POS) && pos < PW'(gpthc_pkg::ECRC_POS + 4)) begin
          ecw_next = ecw_next | lane_word;
        end
        if (pos < PW'(gpthc_pkg::HCRC_POS) || pos_ext < hlw_next) begin
          crc_next = gpthc_pkg::crc_feed(crc, fed);
        end
        pos_next = pos + PW'(1);
      end
    end else begin
      crc_next = gpthc_pkg::crc_feed(crc, item.data_byte);
    end

    res.run_kind     = item.mode;
    res.computed_crc = ~crc_next;
    if (item.mode == gpthc_pkg::MODE_HEADER) begin
      res.stored_crc   = hcw_next;
      res.signature_ok = sig_next && (pos_next >= PW'(gpthc_pkg::SIG_LEN));
      res.short_sector = pos_next < PW'(gpthc_pkg::SECTOR_BYTES);
      res.size_bad     = (hlw_next < 32'(gpthc_pkg::MIN_HDR)) ||
                         (hlw_next > 32'(gpthc_pkg::SECTOR_BYTES));
      res.crc_ok       = (~crc_next == hcw_next) && !res.short_sector && !res.size_bad;
    end else begin
      res.stored_crc   = ecw_next;
      res.signature_ok = 1'b0;
      res.short_sector = 1'b0;
      res.size_bad     = 1'b0;
      res.crc_ok       = (~crc_next == ecw_next);
    end

    if (item.last) begin
      crc_next = gpthc_pkg::CRC_INIT;
      pos_next = '0;
      sig_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= gpthc_pkg::CRC_INIT;
      pos <= '0;
      sig <= 1'b1;
      hlw <= '0;
      hcw <= '0;
      ecw <= '0;
    end else if (take) begin
      crc <= crc_next;
      pos <= pos_next;
      sig <= sig_next;
      hlw <= hlw_next;
      hcw <= hcw_next;
      ecw <= ecw_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/gpthc_out_stage.sv
// Result register: holds one result word until the consumer takes it.
`default_nettype none
module gpthc_out_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                res_load,
  input  wire gpthc_pkg::result_t  res,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output gpthc_pkg::result_t       held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      held <= res;
    end
  end

endmodule
`default_nettype wire

// File: sv/gpt_header_and_entries_checker.sv
// Top level of the GPT header and partition-entry array checker.
// Takes one byte word per cycle; while a result waits downstream it keeps taking bytes
// until the next last byte, which holds in the input register until that result leaves.
// A byte is registered in the input register, then the core updates the CRC and
// captured fields as it takes the byte; the result word is registered in the output
// register on the last byte, and a stalled earlier result delays the later result.
// The byte-wide reflected CRC-32 update in the core sets the clock period. Each run
// ends on its last byte and yields one result word; header runs (mode 0) check
// signature, size and header CRC, entry runs (mode 1) check the CRC against the
// entries CRC captured by the latest header run.
`default_nettype none
module gpt_header_and_entries_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        mode,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             run_kind,
  output logic             signature_ok,
  output logic             short_sector,
  output logic             size_bad,
  output logic             crc_ok,
  output logic [31:0]      computed_crc,
  output logic [31:0]      stored_crc
);

  logic                item_valid;
  gpthc_pkg::item_t    item;
  logic                take;
  logic                res_load;
  gpthc_pkg::result_t  res;
  gpthc_pkg::result_t  held;

  gpthc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .mode       (mode),
    .last       (last),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  gpthc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_full   (out_valid),
    .out_stall  (out_stall),
    .res_load   (res_load),
    .res        (res)
  );

  gpthc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  assign run_kind     = held.run_kind;
  assign signature_ok = held.signature_ok;
  assign short_sector = held.short_sector;
  assign size_bad     = held.size_bad;
  assign crc_ok       = held.crc_ok;
  assign computed_crc = held.computed_crc;
  assign stored_crc   = held.stored_crc;

endmodule
`default_nettype wire

// File: sv/gpthc_checker.sv
// Port-level assertions for the GPT checker, bound to the top level.
`default_nettype none
module gpthc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        run_kind,
  input wire logic        signature_ok,
  input wire logic        short_sector,
  input wire logic        size_bad,
  input wire logic        crc_ok,
  input wire logic [31:0] computed_crc,
  input wire logic [31:0] stored_crc
);

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result word shown straight after reset");

  a_held_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(computed_crc) && $stable(stored_crc))
    else $error("stalled result word changed");

  a_crc_ok_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && crc_ok |-> computed_crc == stored_crc)
    else $error("crc_ok with differing CRCs");

  a_entry_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_kind |-> !signature_ok && !short_sector && !size_bad)
    else $error("header flags set on entry result");

  a_header_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_kind && crc_ok |-> !short_sector && !size_bad)
    else $error("header crc_ok despite size fault");

endmodule

bind gpt_header_and_entries_checker gpthc_checker u_gpthc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .run_kind     (run_kind),
  .signature_ok (signature_ok),
  .short_sector (short_sector),
  .size_bad     (size_bad),
  .crc_ok       (crc_ok),
  .computed_crc (computed_crc),
  .stored_crc   (stored_crc)
);
`default_nettype wire
